FILE: rtl/core/rsort_pkg.sv
// Shared types and constants for the sorting record store.
// No dependencies; used by the cell and top-level modules.
package rsort_pkg;

  localparam int NameBits = 240;

  typedef struct packed {
    logic [31:0]         id;
    logic [NameBits-1:0] name;
    logic [31:0]         score;
  } rec_t;

  // Lower ASCII letters; all other bytes pass through unchanged.
  function automatic logic [7:0] lower_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

endpackage

FILE: rtl/core/rsort_cell.sv
// One cell of the insertion chain: holds a record and a valid bit.
// Depends on rsort_pkg for the record type.
module rsort_cell
  import rsort_pkg::*;
#(
  parameter int NAME_BYTES = 30
) (
  input  logic clk,
  input  logic rst,
  input  logic ins,       // insertion of new record this cycle
  input  logic shift_out, // emit shift toward cell 0
  input  rec_t new_rec,
  input  logic prev_vld,
  input  logic prev_after,
  input  rec_t prev_rec,
  input  logic next_vld,
  input  rec_t next_rec,
  output logic vld,
  output logic after,     // held record must come after new one
  output rec_t rec
);

  localparam int Lim = (NAME_BYTES < 30) ? NAME_BYTES : 30;

  // Byte-wise combinational compare folded from the last byte to the first.
  logic gt;
  always_comb begin
    logic [7:0] ca;
    logic [7:0] cb;
    logic       dec;
    logic       res;
    dec = 1'b0;
    res = 1'b0;
    for (int k = Lim - 1; k >= 0; k--) begin
      ca = lower_byte(rec.name[NameBits-1-8*k -: 8]);
      cb = lower_byte(new_rec.name[NameBits-1-8*k -: 8]);
      if (ca != cb) begin
        dec = 1'b1;
        res = ca > cb;
      end else if (ca == 8'h00) begin
        dec = 1'b0;
        res = 1'b0;
      end
    end
    gt = dec ? res : ($signed(rec.score) < $signed(new_rec.score));
  end

  assign after = vld && gt;

  // On insert, cells past the insertion point take their left neighbor, the cell at the
  // insertion point takes the new record, and the first empty cell grows the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (shift_out) begin
      vld <= next_vld;
      rec <= next_rec;
    end else if (ins) begin
      if (prev_after) begin
        vld <= 1'b1;
        rec <= prev_rec;
      end else if (after || (prev_vld && !vld)) begin
        vld <= 1'b1;
        rec <= new_rec;
      end
    end
  end

endmodule

FILE: rtl/core/record_sort_name_nocase_score_desc.sv
// Top level of the sorting record store: chain of insertion cells and drain.
// Depends on rsort_pkg and rsort_cell.
//
// Channel | Direction | Signals
// in      | sink      | in_valid, in_stall, rec_id, name_word0..3, score_q16, final_record
// out     | source    | out_valid, out_stall, out_id, out_name0..3, out_score, out_final,
//         |           | overflowed
//
// A non-final record is stored unless the chain is full; inputs are taken every cycle while not draining.
// A final record is stored, then the chain shifts one record per transfer
// toward cell 0; the input stalls until the last record has left.
// Reset clears all valid bits and the overflow flag.
module record_sort_name_nocase_score_desc
  import rsort_pkg::*;
#(
  parameter int MAX_RECORDS = 64,
  parameter int NAME_BYTES  = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] rec_id,
  input  logic [63:0] name_word0,
  input  logic [63:0] name_word1,
  input  logic [63:0] name_word2,
  input  logic [47:0] name_word3,
  input  logic [31:0] score_q16,
  input  logic        final_record,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_id,
  output logic [63:0] out_name0,
  output logic [63:0] out_name1,
  output logic [63:0] out_name2,
  output logic [47:0] out_name3,
  output logic [31:0] out_score,
  output logic        out_final,
  output logic        overflowed
);

  logic draining;
  logic dropped;
  logic in_xfer;
  logic out_xfer;
  logic full;
  logic ins;
  rec_t new_rec;

  logic [MAX_RECORDS:0]   vld;
  logic [MAX_RECORDS-1:0] aft;
  rec_t                   recs [MAX_RECORDS+1];

  assign in_stall = draining;
  assign in_xfer  = in_valid && !draining;
  assign out_xfer = out_valid && !out_stall;
  assign full     = vld[MAX_RECORDS-1];
  assign ins      = in_xfer && !full;
  assign new_rec  = '{id: rec_id, name: {name_word0, name_word1, name_word2, name_word3},
                      score: score_q16};

  // Boundary cells of the chain.
  assign vld[MAX_RECORDS]  = 1'b0;
  assign recs[MAX_RECORDS] = new_rec;

  // The insertion chain; cell i takes its neighbor at i-1 on insert.
  // Cell 0 sees a valid left neighbor that never comes after the new record.
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rsort_cell #(.NAME_BYTES(NAME_BYTES)) u_cell (
      .clk(clk), .rst(rst), .ins(ins), .shift_out(draining && out_xfer),
      .new_rec(new_rec),
      .prev_vld((i == 0) ? 1'b1 : vld[(i == 0) ? 0 : i-1]),
      .prev_after((i == 0) ? 1'b0 : aft[(i == 0) ? 0 : i-1]),
      .prev_rec(recs[(i == 0) ? 0 : i-1]),
      .next_vld(vld[i+1]), .next_rec(recs[i+1]),
      .vld(vld[i]), .after(aft[i]), .rec(recs[i])
    );
  end

  // Drain control and overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      if (in_xfer && full) dropped <= 1'b1;
      if (in_xfer && final_record) draining <= 1'b1;
      if (draining && out_xfer && !vld[1]) begin
        draining <= 1'b0;
        dropped  <= 1'b0;
      end
      if (draining && !vld[0]) begin
        draining <= 1'b0;
        dropped  <= 1'b0;
      end
    end
  end

  assign out_valid  = draining && vld[0];
  assign out_id     = recs[0].id;
  assign out_name0  = recs[0].name[239:176];
  assign out_name1  = recs[0].name[175:112];
  assign out_name2  = recs[0].name[111:48];
  assign out_name3  = recs[0].name[47:0];
  assign out_score  = recs[0].score;
  assign out_final  = !vld[1];
  assign overflowed = dropped;

`ifndef SYNTH
  // The chain is packed toward cell 0: cell 1 is never valid while cell 0 is empty.
  a_packed: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> vld[0]) else $error("gap in chain");
  // No input transfer while draining.
  a_nodrain_in: assert property (@(posedge clk) disable iff (rst)
    draining |-> in_stall) else $error("input taken during drain");
  // Output only while draining.
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> draining) else $error("output outside drain");
`endif

endmodule
